@@ hw/rtl/rgs_pkg.sv @@
// Shared constants, codes and types for the ramped gain stage.
package rgs_pkg;

	// Fixed field and state widths
	localparam int GAIN_W       = 24;
	localparam int FRAMES_W     = 13;
	localparam int RAMP_EXTRA   = 15;
	localparam int RAMP_W       = 40;
	localparam int APPLY_W      = RAMP_W - RAMP_EXTRA;
	localparam int FRAMES_RESET = 256;

	// Configuration port
	localparam int CFG_DATA_W = GAIN_W;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES      = 1'd1;

	// Defaults for the top-level parameters
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 16;
	localparam int MAX_FRAMES_DEF     = 4096;

	// Queue depths (powers of two)
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

	// Step divider
	localparam int DIV_CNT_W = $clog2(RAMP_W);

	typedef enum logic {
		FR_ACCEPT,
		FR_WAIT
	} rgs_front_state_t;

	typedef struct packed {
		logic bypass;
		logic last;
	} rgs_flags_t;

	typedef struct packed {
		logic                start;
		logic                negate;
		logic [RAMP_W-1:0]   dividend;
		logic [FRAMES_W-1:0] divisor;
	} rgs_div_req_t;

	typedef struct packed {
		logic              done;
		logic [RAMP_W-1:0] quotient;
	} rgs_div_rsp_t;

endpackage

@@ hw/rtl/ramped_gain_stage_top.sv @@
// Top level of the ramped gain stage: front end, middle queue, back end, output queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  config   | cfg_wr_en          | cfg_index, cfg_data
//  input    | push / full        | sample_in, channel_start, buffer_end
//  result   | empty / pop        | sample_out, clipped, last_of_buffer
//
//  One item per cycle when the gain is steady or a ramp just advances.
//  A channel start while the gain ramps stalls the input until the step is known:
//  the step is divided out one quotient bit per cycle by the restoring divider.
//  A result passes the middle queue, the multiply stage and the output queue.
//  Reset is asynchronous and active low; it restores unity gain and a 256-frame ramp.
//  Either side may stall: full rises when the four-beat middle queue is full,
//  and the back end stops when the four-beat output queue has no free slot.
module ramped_gain_stage_top #(
	parameter int SAMPLE_BITS    = rgs_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = rgs_pkg::GAIN_FRAC_BITS_DEF,
	parameter int MAX_FRAMES     = rgs_pkg::MAX_FRAMES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic signed [SAMPLE_BITS-1:0]  sample_in,
	input  logic                           channel_start,
	input  logic                           buffer_end,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [SAMPLE_BITS-1:0]  sample_out,
	output logic                           clipped,
	output logic                           last_of_buffer
);
	import rgs_pkg::*;

	localparam int ITEM_W = SAMPLE_BITS + APPLY_W + 2;
	localparam int RES_W  = SAMPLE_BITS + 2;

	logic                 mid_wr;
	logic [ITEM_W-1:0]    mid_wdata;
	logic                 mid_full;
	logic                 mid_rd;
	logic [ITEM_W-1:0]    mid_rdata;
	logic                 mid_empty;
	logic [$clog2(MID_DEPTH):0] mid_count;

	logic                 out_wr;
	logic [RES_W-1:0]     out_wdata;
	logic                 out_full;
	logic [RES_W-1:0]     out_rdata;
	logic [OUT_CNT_W-1:0] out_count;
	logic                 out_rd;
	logic                 out_empty;

	rgs_front #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.MAX_FRAMES     (MAX_FRAMES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.sample_in     (sample_in),
		.channel_start (channel_start),
		.buffer_end    (buffer_end),
		.mid_wr        (mid_wr),
		.mid_data      (mid_wdata),
		.mid_full      (mid_full)
	);

	rgs_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_rd),
		.rd_data (mid_rdata),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	rgs_back #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_data  (mid_rdata),
		.mid_empty (mid_empty),
		.mid_rd    (mid_rd),
		.out_count (out_count),
		.out_full  (out_full),
		.out_wr    (out_wr),
		.out_data  (out_wdata)
	);

	rgs_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_wdata),
		.full    (out_full),
		.rd_en   (out_rd),
		.rd_data (out_rdata),
		.empty   (out_empty),
		.count   (out_count)
	);

	// Drain a result beat on pop
	assign out_rd = pop && !out_empty;
	assign empty  = out_empty;
	assign {sample_out, clipped, last_of_buffer} = out_rdata;

	a_mid_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mid_full |-> (mid_count == ($clog2(MID_DEPTH)+1)'(MID_DEPTH)))
		else $error("ramped_gain_stage_top: middle queue full flag out of step");

endmodule

@@ hw/rtl/rgs_fifo.sv @@
// Small register-based first-in first-out queue.
module rgs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	output logic                       full,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     count
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full && !rd_en))
		else $error("rgs_fifo: write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && empty))
		else $error("rgs_fifo: read from an empty queue");

endmodule

@@ hw/rtl/rgs_div.sv @@
// Iterative restoring divider for the ramp step, one quotient bit per cycle.
module rgs_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rgs_pkg::rgs_div_req_t req,
	output rgs_pkg::rgs_div_rsp_t rsp
);
	import rgs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RAMP_W-1:0]    quo_q;
	logic [FRAMES_W-1:0]  rem_q;
	logic [FRAMES_W-1:0]  div_q;
	logic                 neg_q;

	logic [FRAMES_W:0]    rem_sh;
	logic                 take;
	logic [FRAMES_W-1:0]  rem_nx;
	logic                 last_step;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh    = {rem_q, quo_q[RAMP_W-1]};
		take      = (rem_sh >= {1'b0, div_q});
		rem_nx    = take ? FRAMES_W'(rem_sh - {1'b0, div_q}) : rem_sh[FRAMES_W-1:0];
		last_step = busy_q && (cnt_q == DIV_CNT_W'(RAMP_W - 1));
	end

	// Hold operands and shift the quotient in
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
			neg_q <= req.negate;
		end else if (busy_q) begin
			quo_q <= {quo_q[RAMP_W-2:0], take};
			rem_q <= rem_nx;
		end
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Truncate toward zero: divide magnitudes, then restore the sign
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (RAMP_W'(0) - quo_q) : quo_q;

endmodule

@@ hw/rtl/rgs_front.sv @@
// Front end: configuration, gain classification, ramp state and step division.
module rgs_front #(
	parameter int SAMPLE_BITS    = rgs_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = rgs_pkg::GAIN_FRAC_BITS_DEF,
	parameter int MAX_FRAMES     = rgs_pkg::MAX_FRAMES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	input  logic                              channel_start,
	input  logic                              buffer_end,
	output logic                              mid_wr,
	output logic [SAMPLE_BITS+rgs_pkg::APPLY_W+1:0] mid_data,
	input  logic                              mid_full
);
	import rgs_pkg::*;

	localparam int DW = GAIN_W + 2;
	localparam logic [GAIN_W-1:0]     GAIN_RESET = GAIN_W'(1 << GAIN_FRAC_BITS);
	localparam logic signed [DW-1:0]  UNITY_X    = DW'(1 << GAIN_FRAC_BITS);
	localparam logic signed [DW-1:0]  BAND       = DW'(2);
	localparam int SIGN_PAD = RAMP_W - GAIN_W - RAMP_EXTRA;

	rgs_front_state_t state_q, state_d;

	logic signed [GAIN_W-1:0] target_q;
	logic [FRAMES_W-1:0]      frames_q;
	logic signed [GAIN_W-1:0] applied_q;
	logic [RAMP_W-1:0]        ramp_gain_q;
	logic [RAMP_W-1:0]        ramp_step_q;

	logic                     accept;
	logic                     same;
	logic signed [DW-1:0]     unity_off;
	logic                     near_unity;
	logic                     ramp_start;
	logic signed [APPLY_W-1:0] gain;
	logic signed [APPLY_W-1:0] diff;
	logic [APPLY_W-1:0]       diff_mag;
	logic [RAMP_W-1:0]        ramp_init;
	logic [FRAMES_W-1:0]      divisor;
	rgs_flags_t               flags;
	rgs_div_req_t             div_req;
	rgs_div_rsp_t             div_rsp;

	// Classify the item and pick the gain it gets
	always_comb begin
		accept     = push && !full;
		same       = (target_q == applied_q);
		unity_off  = DW'(target_q) - UNITY_X;
		near_unity = (unity_off >= -BAND) && (unity_off <= BAND);
		ramp_start = accept && !same && channel_start;
		ramp_init  = {{SIGN_PAD{applied_q[GAIN_W-1]}}, applied_q, RAMP_EXTRA'(0)};
		if (same) begin
			gain = APPLY_W'(target_q);
		end else if (channel_start) begin
			gain = APPLY_W'(applied_q);
		end else begin
			gain = ramp_gain_q[RAMP_W-1:RAMP_EXTRA];
		end
		flags.bypass = same && near_unity;
		flags.last   = buffer_end;
	end

	// Step request: |target - applied| scaled up, over the clamped ramp length
	always_comb begin
		diff     = APPLY_W'(target_q) - APPLY_W'(applied_q);
		diff_mag = diff[APPLY_W-1] ? (APPLY_W'(0) - diff) : diff;
		if (frames_q == '0) begin
			divisor = FRAMES_W'(1);
		end else if (int'(frames_q) > MAX_FRAMES) begin
			divisor = FRAMES_W'(MAX_FRAMES);
		end else begin
			divisor = frames_q;
		end
		div_req.start    = ramp_start;
		div_req.negate   = diff[APPLY_W-1];
		div_req.dividend = {diff_mag, RAMP_EXTRA'(0)};
		div_req.divisor  = divisor;
	end

	rgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign full     = (state_q != FR_ACCEPT) || mid_full;
	assign mid_wr   = accept;
	assign mid_data = {sample_in, gain, flags};

	// Next state: wait for the step after a ramp restart
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_ACCEPT: begin
				if (ramp_start) begin
					state_d = FR_WAIT;
				end
			end
			FR_WAIT: begin
				if (div_rsp.done) begin
					state_d = FR_ACCEPT;
				end
			end
			default: state_d = FR_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration and gain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= GAIN_RESET;
			frames_q    <= FRAMES_W'(FRAMES_RESET);
			applied_q   <= GAIN_RESET;
			ramp_gain_q <= '0;
			ramp_step_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TARGET_GAIN: target_q <= cfg_data[GAIN_W-1:0];
					CFG_FRAMES:      frames_q <= cfg_data[FRAMES_W-1:0];
					default:         ;
				endcase
			end
			if (accept) begin
				if (buffer_end) begin
					applied_q <= target_q;
				end
				if (!same) begin
					if (channel_start) begin
						ramp_gain_q <= ramp_init;
					end else begin
						ramp_gain_q <= ramp_gain_q + ramp_step_q;
					end
				end
			end else if (div_rsp.done) begin
				ramp_step_q <= div_rsp.quotient;
				ramp_gain_q <= ramp_gain_q + div_rsp.quotient;
			end
		end
	end

	a_no_push_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FR_WAIT) |-> !mid_wr)
		else $error("rgs_front: item queued before the ramp step is known");

	a_restart_waits: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_start |=> (state_q == FR_WAIT))
		else $error("rgs_front: ramp restart did not wait for the divider");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == FR_WAIT))
		else $error("rgs_front: divider finished with nobody waiting");

endmodule

@@ hw/rtl/rgs_back.sv @@
// Back end: multiply, round, saturate and hand results to the output queue.
module rgs_back #(
	parameter int SAMPLE_BITS    = rgs_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = rgs_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [SAMPLE_BITS+rgs_pkg::APPLY_W+1:0] mid_data,
	input  logic                                    mid_empty,
	output logic                                    mid_rd,
	input  logic [rgs_pkg::OUT_CNT_W-1:0]           out_count,
	input  logic                                    out_full,
	output logic                                    out_wr,
	output logic [SAMPLE_BITS+1:0]                  out_data
);
	import rgs_pkg::*;

	localparam int PW = SAMPLE_BITS + APPLY_W;
	localparam int RW = PW - GAIN_FRAC_BITS;
	localparam logic signed [PW-1:0] RND = PW'(1 << (GAIN_FRAC_BITS - 1));
	localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic signed [APPLY_W-1:0]     in_gain;
	rgs_flags_t                    in_flags;

	logic                          v_s1;
	logic signed [PW-1:0]          prod_s1;
	logic [SAMPLE_BITS-1:0]        samp_s1;
	rgs_flags_t                    flags_s1;

	logic                          room;
	logic signed [PW-1:0]          rounded;
	logic signed [RW-1:0]          scaled;
	logic                          sat_hi;
	logic                          sat_lo;
	logic [SAMPLE_BITS-1:0]        res;
	logic                          clip;

	assign {in_sample, in_gain, in_flags} = mid_data;

	// Take a beat only if the output queue has a slot for it
	always_comb begin
		if (v_s1) begin
			room = (out_count < OUT_CNT_W'(OUT_DEPTH - 1));
		end else begin
			room = (out_count < OUT_CNT_W'(OUT_DEPTH));
		end
		mid_rd = !mid_empty && room;
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (mid_rd) begin
			prod_s1  <= in_sample * in_gain;
			samp_s1  <= in_sample;
			flags_s1 <= in_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= mid_rd;
		end
	end

	// Round half up, drop the fraction, clamp to the sample range; bypassed samples pass unchanged
	always_comb begin
		rounded = prod_s1 + RND;
		scaled  = rounded[PW-1:GAIN_FRAC_BITS];
		sat_hi  = !scaled[RW-1] && (|scaled[RW-2:SAMPLE_BITS-1]);
		sat_lo  = scaled[RW-1] && !(&scaled[RW-2:SAMPLE_BITS-1]);
		if (flags_s1.bypass) begin
			res  = samp_s1;
			clip = 1'b0;
		end else if (sat_hi) begin
			res  = SAT_MAX;
			clip = 1'b1;
		end else if (sat_lo) begin
			res  = SAT_MIN;
			clip = 1'b1;
		end else begin
			res  = scaled[SAMPLE_BITS-1:0];
			clip = 1'b0;
		end
	end

	assign out_wr   = v_s1;
	assign out_data = {res, clip, flags_s1.last};

	a_slot_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> !out_full)
		else $error("rgs_back: result produced with no slot in the output queue");

endmodule
